FILE: sv/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes for the first-fit run allocator: result status
// codes, opcodes and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Run length field width and the widest window a run can cover.
  localparam int LEN_W = 2;
  localparam int WIN_W = 3;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FAIL = 2'd1,
    ST_HELD = 2'd2
  } status_t;

  // Which result the datapath loads into the output register.
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_HELD,
    RES_FREE,
    RES_ALLOC
  } res_sel_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     scan_start;
    logic     scan_next;
    logic     do_free;
    logic     do_alloc;
    logic     load_res;
    res_sel_t res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;
    logic is_free;
    logic rec_valid;
    logic len_ok;
    logic found;
    logic last_bank;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Controller: takes a request, checks it against the owner record and
// either completes it from the check or walks the banks one per cycle.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ffra_pkg::dp_status_t  st,
  output ffra_pkg::cmd_t        cmd
);
  import ffra_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.res_sel = RES_FAIL;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // An allocate that passes all checks goes on to the bank scan.
        if (st.id_ok && !st.is_free && !st.rec_valid && st.len_ok) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (st.out_free) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
          priority if (!st.id_ok) begin
            cmd.res_sel = RES_FAIL;
          end else if (st.is_free && st.rec_valid) begin
            cmd.do_free = 1'b1;
            cmd.res_sel = RES_FREE;
          end else if (st.is_free) begin
            cmd.res_sel = RES_FAIL;
          end else if (st.rec_valid) begin
            cmd.res_sel = RES_HELD;
          end else begin
            cmd.res_sel = RES_FAIL;
          end
        end
      end
      S_SCAN: begin
        if (st.found || st.last_bank) begin
          if (st.out_free) begin
            cmd.load_res = 1'b1;
            state_next   = S_IDLE;
            if (st.found) begin
              cmd.do_alloc = 1'b1;
              cmd.res_sel  = RES_ALLOC;
            end else begin
              cmd.res_sel  = RES_FAIL;
            end
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Datapath: occupancy rows, owner records, the per-bank first-fit search,
// the request registers and the output register.
// ----------------------------------------------------------------------------
module ffra_dp #(
  parameter int BANKS          = 4,
  parameter int SLOTS_PER_BANK = 16,
  parameter int MAX_RUN        = 3,
  parameter int OWNERS         = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  opcode,
  input  logic [3:0]            owner_id,
  input  logic [1:0]            run_length,
  output logic [1:0]            status,
  output logic [1:0]            bank,
  output logic [3:0]            first_slot,
  output logic [3:0]            last_slot,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ffra_pkg::cmd_t        cmd,
  output ffra_pkg::dp_status_t  st
);
  import ffra_pkg::*;

  localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int SW  = (SLOTS_PER_BANK > 1) ? $clog2(SLOTS_PER_BANK) : 1;
  localparam int OW  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
  localparam int RW  = BW + 2 * SW;

  // Request registers.
  logic             req_op;
  logic [3:0]       req_id;
  logic [LEN_W-1:0] req_len;
  logic [OW-1:0]    req_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op  <= opcode;
      req_id  <= owner_id;
      req_len <= run_length;
    end
  end

  assign req_idx = OW'(req_id);

  // Owner records: valid bits in flops, the fields in a memory.
  logic [OWNERS-1:0] rec_valid;
  logic [RW-1:0]     rec_mem [OWNERS];
  logic [RW-1:0]     rec_q;
  logic [BW-1:0]     rec_bank;
  logic [SW-1:0]     rec_first;
  logic [SW-1:0]     rec_last;

  assign rec_bank  = rec_q[RW-1 -: BW];
  assign rec_first = rec_q[2*SW-1 -: SW];
  assign rec_last  = rec_q[SW-1:0];

  // Bank scan counter.
  logic [BW-1:0] bank_cnt;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      bank_cnt <= '0;
    end else if (cmd.scan_next) begin
      bank_cnt <= bank_cnt + BW'(1);
    end
  end

  // Occupancy rows.
  logic [SLOTS_PER_BANK-1:0] occ [BANKS];

  // First-fit search in the bank under the counter. The row is padded with
  // taken slots so that a run may not reach past the end of the bank.
  logic [WIN_W-1:0]                len_mask;
  logic [SLOTS_PER_BANK+WIN_W-1:0] padded;
  logic [SLOTS_PER_BANK-1:0]       fit;
  logic [SW-1:0]                   pos;
  logic [SW-1:0]                   alloc_last;
  logic [SLOTS_PER_BANK-1:0]       alloc_mask;
  logic [SLOTS_PER_BANK-1:0]       free_mask;

  always_comb begin
    unique case (req_len)
      2'd1:    len_mask = 3'b001;
      2'd2:    len_mask = 3'b011;
      2'd3:    len_mask = 3'b111;
      default: len_mask = 3'b000;
    endcase
  end

  assign padded = {{WIN_W{1'b1}}, occ[bank_cnt]};

  always_comb begin
    for (int s = 0; s < SLOTS_PER_BANK; s++) begin
      fit[s] = ((padded[s +: WIN_W] & len_mask) == '0);
    end
  end

  // Lowest fitting position.
  always_comb begin
    pos = '0;
    for (int s = SLOTS_PER_BANK - 1; s >= 0; s--) begin
      if (fit[s]) begin
        pos = SW'(s);
      end
    end
  end

  assign alloc_last = SW'(32'(pos) + 32'(req_len) - 32'd1);
  assign alloc_mask = SLOTS_PER_BANK'(len_mask) << pos;

  // Slots covered by the recorded run of the owner being freed.
  always_comb begin
    for (int s = 0; s < SLOTS_PER_BANK; s++) begin
      free_mask[s] = (SW'(s) >= rec_first) && (SW'(s) <= rec_last);
    end
  end

  // Occupancy update on allocate and free.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANKS; b++) begin
        occ[b] <= '0;
      end
    end else if (cmd.do_alloc) begin
      occ[bank_cnt] <= occ[bank_cnt] | alloc_mask;
    end else if (cmd.do_free) begin
      occ[rec_bank] <= occ[rec_bank] & ~free_mask;
    end
  end

  // Record valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
    end else if (cmd.do_alloc) begin
      rec_valid[req_idx] <= 1'b1;
    end else if (cmd.do_free) begin
      rec_valid[req_idx] <= 1'b0;
    end
  end

  // Record memory: read when a request is taken, written on allocate.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rec_q <= rec_mem[OW'(owner_id)];
    end
    if (cmd.do_alloc) begin
      rec_mem[req_idx] <= {bank_cnt, pos, alloc_last};
    end
  end

  // Status toward the controller.
  assign st.id_ok     = (32'(req_id) < 32'(OWNERS));
  assign st.is_free   = (req_op == OP_FREE);
  assign st.rec_valid = st.id_ok && rec_valid[req_idx];
  assign st.len_ok    = (req_len != '0) && (32'(req_len) <= 32'(MAX_RUN))
                        && (32'(req_len) <= 32'(SLOTS_PER_BANK));
  assign st.found     = |fit;
  assign st.last_bank = (bank_cnt == BW'(BANKS - 1));
  assign st.out_free  = !out_valid || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      unique case (cmd.res_sel)
        RES_ALLOC: begin
          status     <= ST_DONE;
          bank       <= 2'(bank_cnt);
          first_slot <= 4'(pos);
          last_slot  <= 4'(alloc_last);
        end
        RES_FREE: begin
          status     <= ST_DONE;
          bank       <= 2'(rec_bank);
          first_slot <= 4'(rec_first);
          last_slot  <= 4'(rec_last);
        end
        RES_HELD: begin
          status     <= ST_HELD;
          bank       <= '0;
          first_slot <= '0;
          last_slot  <= '0;
        end
        RES_FAIL: begin
          status     <= ST_FAIL;
          bank       <= '0;
          first_slot <= '0;
          last_slot  <= '0;
        end
      endcase
    end
  end

endmodule

FILE: sv/first_fit_run_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_run_allocator_unit: contiguous slot run allocator, first fit.
// Flow from the input transfer to a valid result: free and rejected requests
// are settled in the check state; an allocate goes on to the bank scan, one
// bank a cycle from bank 0 until a bank takes the run or the last bank fails.
// Results load only when the output register is free. One request at a time;
// the next transfer is taken in the idle state after the result loads.
// Reset clears all occupancy and owner valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_run_allocator_unit #(
  parameter int BANKS          = 4,
  parameter int SLOTS_PER_BANK = 16,
  parameter int MAX_RUN        = 3,
  parameter int OWNERS         = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [3:0] owner_id,
  input  logic [1:0] run_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [1:0] bank,
  output logic [3:0] first_slot,
  output logic [3:0] last_slot
);
  import ffra_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  // Controller.
  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  ffra_dp #(
    .BANKS          (BANKS),
    .SLOTS_PER_BANK (SLOTS_PER_BANK),
    .MAX_RUN        (MAX_RUN),
    .OWNERS         (OWNERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (opcode),
    .owner_id   (owner_id),
    .run_length (run_length),
    .status     (status),
    .bank       (bank),
    .first_slot (first_slot),
    .last_slot  (last_slot),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .st         (st)
  );

  // A failed or rejected request reports a zero location.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> (bank == '0) && (first_slot == '0)
                                         && (last_slot == '0))
    else $error("nonzero location on a failed request");

  // Only one request is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // A result is never produced in the cycle right after an idle cycle.
  a_no_idle_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a request in work");

endmodule
